// ===== rtl/tgcs_pkg.sv =====
// shared types, constants and the 5x7 font table for the text glyph column streamer
package tgcs_pkg;

  localparam logic [7:0] FONT_FIRST   = 8'h20;
  localparam logic [7:0] FONT_ENTRIES = 8'd98;
  localparam int         FONT_COLS    = 5;
  localparam logic [7:0] NEWLINE_CODE = 8'h0A;

  // glyph column index width, enough for the widest glyph
  localparam int IDX_W = 3;

  localparam logic MODE_RENDER     = 1'b0;
  localparam logic MODE_SET_CURSOR = 1'b1;

  localparam logic KIND_DATA   = 1'b0;
  localparam logic KIND_CURSOR = 1'b1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GLYPH,
    ST_SPACER
  } seq_state_t;

  // one glyph row, leftmost column in the top byte
  function automatic logic [39:0] font_row(input logic [6:0] idx);
    logic [39:0] row;
    case (idx)
      7'd0:  row = 40'h0000000000;
      7'd1:  row = 40'h00002F0000;
      7'd2:  row = 40'h0007000700;
      7'd3:  row = 40'h147F147F14;
      7'd4:  row = 40'h242A7F2A12;
      7'd5:  row = 40'h2313086462;
      7'd6:  row = 40'h3649552250;
      7'd7:  row = 40'h0005030000;
      7'd8:  row = 40'h001C224100;
      7'd9:  row = 40'h0041221C00;
      7'd10: row = 40'h14083E0814;
      7'd11: row = 40'h08083E0808;
      7'd12: row = 40'h0000A06000;
      7'd13: row = 40'h0808080808;
      7'd14: row = 40'h0060600000;
      7'd15: row = 40'h2010080402;
      7'd16: row = 40'h3E5149453E;
      7'd17: row = 40'h00427F4000;
      7'd18: row = 40'h4261514946;
      7'd19: row = 40'h2141454B31;
      7'd20: row = 40'h1814127F10;
      7'd21: row = 40'h2745454539;
      7'd22: row = 40'h3C4A494930;
      7'd23: row = 40'h0171090503;
      7'd24: row = 40'h3649494936;
      7'd25: row = 40'h064949291E;
      7'd26: row = 40'h0036360000;
      7'd27: row = 40'h0056360000;
      7'd28: row = 40'h0814224100;
      7'd29: row = 40'h1414141414;
      7'd30: row = 40'h0041221408;
      7'd31: row = 40'h0201510906;
      7'd32: row = 40'h324959513E;
      7'd33: row = 40'h7C1211127C;
      7'd34: row = 40'h7F49494936;
      7'd35: row = 40'h3E41414122;
      7'd36: row = 40'h7F4141221C;
      7'd37: row = 40'h7F49494941;
      7'd38: row = 40'h7F09090901;
      7'd39: row = 40'h3E4149497A;
      7'd40: row = 40'h7F0808087F;
      7'd41: row = 40'h00417F4100;
      7'd42: row = 40'h2040413F01;
      7'd43: row = 40'h7F08142241;
      7'd44: row = 40'h7F40404040;
      7'd45: row = 40'h7F020C027F;
      7'd46: row = 40'h7F0408107F;
      7'd47: row = 40'h3E4141413E;
      7'd48: row = 40'h7F09090906;
      7'd49: row = 40'h3E4151215E;
      7'd50: row = 40'h7F09192946;
      7'd51: row = 40'h4649494931;
      7'd52: row = 40'h01017F0101;
      7'd53: row = 40'h3F4040403F;
      7'd54: row = 40'h1F2040201F;
      7'd55: row = 40'h3F4038403F;
      7'd56: row = 40'h6314081463;
      7'd57: row = 40'h0708700807;
      7'd58: row = 40'h6151494543;
      7'd59: row = 40'h007F414100;
      7'd60: row = 40'h55AA55AA55;
      7'd61: row = 40'h0041417F00;
      7'd62: row = 40'h0402010204;
      7'd63: row = 40'h4040404040;
      7'd64: row = 40'h0003050000;
      7'd65: row = 40'h2054545478;
      7'd66: row = 40'h7F48444438;
      7'd67: row = 40'h3844444420;
      7'd68: row = 40'h384444487F;
      7'd69: row = 40'h3854545418;
      7'd70: row = 40'h087E090102;
      7'd71: row = 40'h18A4A4A47C;
      7'd72: row = 40'h7F08040478;
      7'd73: row = 40'h00447D4000;
      7'd74: row = 40'h4080847D00;
      7'd75: row = 40'h7F10284400;
      7'd76: row = 40'h00417F4000;
      7'd77: row = 40'h7C04180478;
      7'd78: row = 40'h7C08040478;
      7'd79: row = 40'h3844444438;
      7'd80: row = 40'hFC24242418;
      7'd81: row = 40'h18242418FC;
      7'd82: row = 40'h7C08040408;
      7'd83: row = 40'h4854545420;
      7'd84: row = 40'h043F444020;
      7'd85: row = 40'h3C4040207C;
      7'd86: row = 40'h1C2040201C;
      7'd87: row = 40'h3C4030403C;
      7'd88: row = 40'h4428102844;
      7'd89: row = 40'h1CA0A0A07C;
      7'd90: row = 40'h4464544C44;
      7'd91: row = 40'h00107C8200;
      7'd92: row = 40'h0000FF0000;
      7'd93: row = 40'h00827C1000;
      7'd94: row = 40'h0006090906;
      7'd95: row = 40'h3C7E7E7E3C;
      7'd96: row = 40'h0030484830;
      7'd97: row = 40'h3C4242423C;
      default: row = 40'h0000000000;
    endcase
    return row;
  endfunction

endpackage

// ===== rtl/tgcs_font_rom.sv =====
// font rom with a registered read port, one glyph column byte per read
module tgcs_font_rom import tgcs_pkg::*; (
  input  logic             clk,
  input  logic             rd_en,
  input  logic             blank,
  input  logic [7:0]       code,
  input  logic [IDX_W-1:0] col_idx,
  output logic [7:0]       rd_data
);

  logic [7:0]  rd_data_r;
  logic [7:0]  offset;
  logic [39:0] row;
  logic        hit;
  logic [7:0]  col_byte;

  assign offset = code - FONT_FIRST;
  assign row    = font_row(offset[6:0]);
  assign hit    = !blank && (code >= FONT_FIRST) && (offset < FONT_ENTRIES);

  always_comb begin
    case (col_idx)
      IDX_W'(0): col_byte = row[39:32];
      IDX_W'(1): col_byte = row[31:24];
      IDX_W'(2): col_byte = row[23:16];
      IDX_W'(3): col_byte = row[15:8];
      IDX_W'(4): col_byte = row[7:0];
      default:   col_byte = 8'h00;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= hit ? col_byte : 8'h00;
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== rtl/text_glyph_column_streamer_top.sv =====
// the first word of an item is in the output register in the cycle after the sequencer takes
// it; the item after the current one is held in a one-word input stage meanwhile
// throughput: one output word per cycle unless out_tready stalls it; an item gives 1 to GLYPH_WIDTH+2
// words (7 at the default width), a dropped set-cursor request gives no word
// reset: synchronous, clears the cursor to column 0 page 0 and empties both stages
module text_glyph_column_streamer_top import tgcs_pkg::*; #(
  parameter int GLYPH_WIDTH     = 5,
  parameter int DISPLAY_COLUMNS = 128,
  parameter int DISPLAY_PAGES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], cursor_column[15:8], cursor_page[23:16]
  input  logic        in_tuser,   // mode
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [23:0] out_tdata,  // pixel_byte[7:0], column[14:8], page[17:15], zero pad
  output logic        out_tuser,  // kind
  output logic        out_tlast
);

  localparam int STEP_W = $clog2(GLYPH_WIDTH);
  localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(GLYPH_WIDTH - 1);

  // input stage
  logic       pend_valid_r;
  logic       pend_mode_r;
  logic [7:0] pend_code_r;
  logic [7:0] pend_col_r;
  logic [7:0] pend_pg_r;

  // sequencer
  seq_state_t        state_r, state_nxt;
  logic [7:0]        code_r, code_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [7:0]        cursor_col_r, cursor_col_nxt;
  logic [2:0]        cursor_line_r, cursor_line_nxt;

  // output register
  logic       out_valid_r;
  logic       out_kind_r;
  logic [6:0] out_col_r;
  logic [2:0] out_page_r;
  logic       out_last_r;
  logic [7:0] pixel;

  logic             adv;
  logic             take;
  logic             emit;
  logic             e_kind;
  logic [7:0]       e_col;
  logic [2:0]       e_page;
  logic             e_last;
  logic             e_blank;
  logic [7:0]       e_code;
  logic [IDX_W-1:0] e_idx;
  logic             wrap_hit;
  logic             is_newline;
  logic [2:0]       next_page;
  logic             req_ok;

  assign adv       = !out_valid_r || out_tready;
  assign take      = (state_r == ST_IDLE) && pend_valid_r && adv;
  assign in_tready = !pend_valid_r || take;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (in_tvalid && in_tready) begin
      pend_valid_r <= 1'b1;
    end else if (take) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      pend_mode_r <= in_tuser;
      pend_code_r <= in_tdata[7:0];
      pend_col_r  <= in_tdata[15:8];
      pend_pg_r   <= in_tdata[23:16];
    end
  end

  assign wrap_hit   = ({1'b0, cursor_col_r} + 9'(GLYPH_WIDTH)) >= 9'(DISPLAY_COLUMNS);
  assign is_newline = (pend_code_r == NEWLINE_CODE);
  assign next_page  = (({1'b0, cursor_line_r} + 4'd1) >= 4'(DISPLAY_PAGES)) ?
                      3'd0 : cursor_line_r + 3'd1;
  assign req_ok     = ({1'b0, pend_col_r} < 9'(DISPLAY_COLUMNS)) &&
                      ({1'b0, pend_pg_r} < 9'(DISPLAY_PAGES));

  always_comb begin
    state_nxt       = state_r;
    code_nxt        = code_r;
    step_nxt        = step_r;
    cursor_col_nxt  = cursor_col_r;
    cursor_line_nxt = cursor_line_r;
    emit            = 1'b0;
    e_kind          = KIND_DATA;
    e_col           = cursor_col_r;
    e_page          = cursor_line_r;
    e_last          = 1'b0;
    e_blank         = 1'b1;
    e_code          = code_r;
    e_idx           = IDX_W'(step_r);
    case (state_r)
      ST_IDLE: begin
        if (take) begin
          if (pend_mode_r == MODE_SET_CURSOR) begin
            // out-of-range requests are dropped without a word
            if (req_ok) begin
              emit            = 1'b1;
              e_kind          = KIND_CURSOR;
              e_col           = pend_col_r;
              e_page          = pend_pg_r[2:0];
              e_last          = 1'b1;
              cursor_col_nxt  = pend_col_r;
              cursor_line_nxt = pend_pg_r[2:0];
            end
          end else begin
            code_nxt = pend_code_r;
            if (is_newline || wrap_hit) begin
              emit            = 1'b1;
              e_kind          = KIND_CURSOR;
              e_col           = 8'd0;
              e_page          = next_page;
              e_last          = is_newline;
              cursor_col_nxt  = 8'd0;
              cursor_line_nxt = next_page;
              if (!is_newline) begin
                state_nxt = ST_GLYPH;
                step_nxt  = '0;
              end
            end else begin
              // first glyph column goes out straight away
              emit           = 1'b1;
              e_blank        = 1'b0;
              e_code         = pend_code_r;
              e_idx          = '0;
              cursor_col_nxt = cursor_col_r + 8'd1;
              step_nxt       = STEP_W'(1);
              state_nxt      = ST_GLYPH;
            end
          end
        end
      end
      ST_GLYPH: begin
        if (adv) begin
          emit           = 1'b1;
          e_blank        = 1'b0;
          cursor_col_nxt = cursor_col_r + 8'd1;
          if (step_r == LAST_STEP) begin
            step_nxt  = '0;
            state_nxt = ST_SPACER;
          end else begin
            step_nxt = step_r + STEP_W'(1);
          end
        end
      end
      ST_SPACER: begin
        if (adv) begin
          emit           = 1'b1;
          e_last         = 1'b1;
          cursor_col_nxt = cursor_col_r + 8'd1;
          state_nxt      = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      step_r        <= '0;
      cursor_col_r  <= 8'd0;
      cursor_line_r <= 3'd0;
    end else begin
      state_r       <= state_nxt;
      step_r        <= step_nxt;
      cursor_col_r  <= cursor_col_nxt;
      cursor_line_r <= cursor_line_nxt;
    end
  end

  always_ff @(posedge clk) begin
    code_r <= code_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= emit;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind_r <= e_kind;
      out_col_r  <= e_col[6:0];
      out_page_r <= e_page;
      out_last_r <= e_last;
    end
  end

  // rom data register lines up with the output register
  tgcs_font_rom u_font_rom (
    .clk     (clk),
    .rd_en   (emit),
    .blank   (e_blank),
    .code    (e_code),
    .col_idx (e_idx),
    .rd_data (pixel)
  );

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'd0, out_page_r, out_col_r, pixel};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

`ifndef SYNTHESIS
  // only the spacer or a single-word item closes an item, and both leave the sequencer idle
  a_last_only_when_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r != ST_IDLE) |-> !(out_tvalid && out_tlast))
    else $error("last word seen while an item is still in progress");

  a_cursor_word_blank: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser == KIND_CURSOR) |-> (out_tdata[7:0] == 8'h00))
    else $error("cursor word carries pixel data");

  a_cursor_col_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cursor_col_r} <= 9'(DISPLAY_COLUMNS))
    else $error("cursor column beyond the display");

  a_cursor_page_range: assert property (@(posedge clk) disable iff (!rst_n)
    {1'b0, cursor_line_r} < 4'(DISPLAY_PAGES))
    else $error("cursor page beyond the display");

  a_take_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    take |-> (!out_valid_r || out_tready))
    else $error("item taken while the output register is stalled");
`endif

endmodule

// ===== tb/sv/text_glyph_column_checker.sv =====
// checker for the glyph column streamer: predicts output words from accepted inputs and compares
`timescale 1ns / 1ps
module text_glyph_column_checker import tgcs_pkg::*; #(
  parameter int GLYPH_WIDTH     = 5,
  parameter int DISPLAY_COLUMNS = 128,
  parameter int DISPLAY_PAGES   = 8
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [23:0] in_tdata,   // char_code[7:0], cursor_column[15:8], cursor_page[23:16]
  input  logic        in_tuser,   // mode
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [23:0] out_tdata,  // pixel_byte[7:0], column[14:8], page[17:15], zero pad
  input  logic        out_tuser,  // kind
  input  logic        out_tlast,
  output int          mismatches,
  output int          backlog
);

  typedef struct packed {
    logic       kind;
    logic [7:0] pixel;
    logic [6:0] column;
    logic [2:0] page;
    logic       last;
  } glyph_word_t;

  // 5x7 font from code 0x20 up, leftmost column in the top byte of each entry
  localparam logic [0:97][39:0] FONT = {
    40'h0000000000, 40'h00002F0000, 40'h0007000700, 40'h147F147F14,
    40'h242A7F2A12, 40'h2313086462, 40'h3649552250, 40'h0005030000,
    40'h001C224100, 40'h0041221C00, 40'h14083E0814, 40'h08083E0808,
    40'h0000A06000, 40'h0808080808, 40'h0060600000, 40'h2010080402,
    40'h3E5149453E, 40'h00427F4000, 40'h4261514946, 40'h2141454B31,
    40'h1814127F10, 40'h2745454539, 40'h3C4A494930, 40'h0171090503,
    40'h3649494936, 40'h064949291E, 40'h0036360000, 40'h0056360000,
    40'h0814224100, 40'h1414141414, 40'h0041221408, 40'h0201510906,
    40'h324959513E, 40'h7C1211127C, 40'h7F49494936, 40'h3E41414122,
    40'h7F4141221C, 40'h7F49494941, 40'h7F09090901, 40'h3E4149497A,
    40'h7F0808087F, 40'h00417F4100, 40'h2040413F01, 40'h7F08142241,
    40'h7F40404040, 40'h7F020C027F, 40'h7F0408107F, 40'h3E4141413E,
    40'h7F09090906, 40'h3E4151215E, 40'h7F09192946, 40'h4649494931,
    40'h01017F0101, 40'h3F4040403F, 40'h1F2040201F, 40'h3F4038403F,
    40'h6314081463, 40'h0708700807, 40'h6151494543, 40'h007F414100,
    40'h55AA55AA55, 40'h0041417F00, 40'h0402010204, 40'h4040404040,
    40'h0003050000, 40'h2054545478, 40'h7F48444438, 40'h3844444420,
    40'h384444487F, 40'h3854545418, 40'h087E090102, 40'h18A4A4A47C,
    40'h7F08040478, 40'h00447D4000, 40'h4080847D00, 40'h7F10284400,
    40'h00417F4000, 40'h7C04180478, 40'h7C08040478, 40'h3844444438,
    40'hFC24242418, 40'h18242418FC, 40'h7C08040408, 40'h4854545420,
    40'h043F444020, 40'h3C4040207C, 40'h1C2040201C, 40'h3C4030403C,
    40'h4428102844, 40'h1CA0A0A07C, 40'h4464544C44, 40'h00107C8200,
    40'h0000FF0000, 40'h00827C1000, 40'h0006090906, 40'h3C7E7E7E3C,
    40'h0030484830, 40'h3C4242423C
  };

  glyph_word_t expected_words[$];
  logic [7:0]  cur_col;
  logic [2:0]  cur_page;
  int          err_count;

  function automatic logic [7:0] glyph_column(input logic [7:0] code, input int idx);
    logic [7:0] slot;
    if (code < FONT_FIRST || idx >= FONT_COLS) return 8'h00;
    slot = code - FONT_FIRST;
    if (slot >= FONT_ENTRIES) return 8'h00;
    return FONT[slot][39 - 8 * idx -: 8];
  endfunction

  task automatic predict_words(input logic mode, input logic [7:0] code,
                               input logic [7:0] req_col, input logic [7:0] req_page);
    int i;
    if (mode == MODE_SET_CURSOR) begin
      // requests off the display are dropped without a word
      if (req_col < DISPLAY_COLUMNS && req_page < DISPLAY_PAGES) begin
        cur_col  = req_col;
        cur_page = req_page[2:0];
        expected_words.push_back('{KIND_CURSOR, 8'h00, req_col[6:0], req_page[2:0], 1'b1});
      end
      return;
    end
    if (code == NEWLINE_CODE || int'(cur_col) + GLYPH_WIDTH >= DISPLAY_COLUMNS) begin
      cur_page = (int'(cur_page) + 1 >= DISPLAY_PAGES) ? 3'd0 : cur_page + 3'd1;
      cur_col  = 8'd0;
      expected_words.push_back('{KIND_CURSOR, 8'h00, 7'd0, cur_page, code == NEWLINE_CODE});
    end
    if (code == NEWLINE_CODE) return;
    for (i = 0; i < GLYPH_WIDTH; i++) begin
      expected_words.push_back('{KIND_DATA, glyph_column(code, i), cur_col[6:0], cur_page, 1'b0});
      cur_col = cur_col + 8'd1;
    end
    // blank spacer column closes the glyph
    expected_words.push_back('{KIND_DATA, 8'h00, cur_col[6:0], cur_page, 1'b1});
    cur_col = cur_col + 8'd1;
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s mismatch: expected 0x%0h, got 0x%0h", name, want, got);
      err_count++;
    end
  endtask

  always @(posedge clk) begin : watch
    glyph_word_t want;
    if (!rst_n) begin
      expected_words.delete();
      cur_col  = 8'd0;
      cur_page = 3'd0;
    end else begin
      if (in_tvalid && in_tready)
        predict_words(in_tuser, in_tdata[7:0], in_tdata[15:8], in_tdata[23:16]);
      if (out_tvalid && out_tready) begin
        if (expected_words.size() == 0) begin
          $error("unexpected word 0x%06h kind %0b last %0b", out_tdata, out_tuser, out_tlast);
          err_count++;
        end else begin
          want = expected_words.pop_front();
          check_field("kind", want.kind, out_tuser);
          check_field("pixel_byte", want.pixel, out_tdata[7:0]);
          check_field("column", want.column, out_tdata[14:8]);
          check_field("page", want.page, out_tdata[17:15]);
          check_field("pad", 0, out_tdata[23:18]);
          check_field("last", want.last, out_tlast);
        end
      end
    end
    mismatches <= err_count;
    backlog    <= expected_words.size();
  end

endmodule

// ===== tb/sv/text_glyph_column_streamer_top_tb.sv =====
// testbench top for the glyph column streamer: stimulus, back-pressure and the verdict
`timescale 1ns / 1ps
module text_glyph_column_streamer_top_tb;
  import tgcs_pkg::*;

  localparam int GLYPH_WIDTH     = 5;
  localparam int DISPLAY_COLUMNS = 128;
  localparam int DISPLAY_PAGES   = 8;
  localparam int HOLD_CYCLES     = 300;
  localparam int IDLE_LIMIT      = 2000;
  localparam int RANDOM_ITEMS    = 405;

  logic        clk;
  logic        rst_n;
  logic        in_tvalid;
  logic        in_tready;
  logic [23:0] in_tdata;
  logic        in_tuser;
  logic        out_tvalid;
  logic        out_tready;
  logic [23:0] out_tdata;
  logic        out_tuser;
  logic        out_tlast;

  int   mismatches;
  int   backlog;
  int   idle_cycles;
  logic hold_request;
  logic no_idle;

  text_glyph_column_streamer_top #(
    .GLYPH_WIDTH     (GLYPH_WIDTH),
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .DISPLAY_PAGES   (DISPLAY_PAGES)
  ) u_top (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  text_glyph_column_checker #(
    .GLYPH_WIDTH     (GLYPH_WIDTH),
    .DISPLAY_COLUMNS (DISPLAY_COLUMNS),
    .DISPLAY_PAGES   (DISPLAY_PAGES)
  ) u_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .mismatches (mismatches),
    .backlog    (backlog)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  task automatic send_word(input logic mode, input logic [7:0] code,
                           input logic [7:0] col, input logic [7:0] page);
    int gap;
    gap = no_idle ? 0 : $urandom_range(0, 12);
    if (gap != 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= mode;
    in_tdata  <= {page, col, code};
    do @(posedge clk); while (!in_tready);
  endtask

  // stop offering words until every predicted word has come out
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    @(posedge clk);
    wait (backlog == 0);
    @(posedge clk);
  endtask

  // receiving side: random stalls per word, plus one long hold on request
  initial begin : sink
    int stall;
    out_tready = 1'b0;
    @(posedge clk);
    forever begin
      if (hold_request) begin
        hold_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      stall = no_idle ? 0 : $urandom_range(0, 12);
      if (stall != 0) begin
        out_tready <= 1'b0;
        repeat (stall) @(posedge clk);
      end
      out_tready <= 1'b1;
      do @(posedge clk); while (!out_tvalid);
    end
  end

  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin : source
    int         counted;
    int         n;
    int         r;
    int         q;
    logic       mode;
    logic [7:0] code;
    logic [7:0] col;
    logic [7:0] page;
    rst_n        = 1'b0;
    in_tvalid    = 1'b0;
    in_tuser     = 1'b0;
    in_tdata     = '0;
    hold_request = 1'b0;
    no_idle      = 1'b0;
    idle_cycles  = 0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    // directed: font edges, codes outside the font, newline, wraps and cursor limits
    send_word(MODE_RENDER, 8'h41, 8'h00, 8'h00);
    send_word(MODE_RENDER, 8'h30, 8'h00, 8'h00);
    send_word(MODE_RENDER, 8'h20, 8'h00, 8'h00);
    send_word(MODE_RENDER, 8'h81, 8'h00, 8'h00);
    send_word(MODE_RENDER, 8'h1F, 8'h00, 8'h00);
    send_word(MODE_RENDER, 8'h82, 8'h00, 8'h00);
    send_word(MODE_RENDER, 8'h00, 8'h00, 8'h00);
    send_word(MODE_RENDER, 8'hFF, 8'hFF, 8'hFF);
    send_word(MODE_RENDER, NEWLINE_CODE, 8'h00, 8'h00);
    send_word(MODE_SET_CURSOR, 8'hFF, 8'd127, 8'd7);
    send_word(MODE_RENDER, 8'h7E, 8'h00, 8'h00);      // wraps from the last page to page 0
    send_word(MODE_SET_CURSOR, 8'h00, 8'd128, 8'd0);
    send_word(MODE_SET_CURSOR, 8'h00, 8'd0, 8'd8);
    send_word(MODE_SET_CURSOR, NEWLINE_CODE, 8'hFF, 8'hFF);
    send_word(MODE_SET_CURSOR, 8'h55, 8'd122, 8'd3);
    send_word(MODE_RENDER, 8'h5A, 8'h00, 8'h00);      // last glyph that fits, spacer on column 127
    send_word(MODE_RENDER, 8'h61, 8'h00, 8'h00);
    send_word(MODE_SET_CURSOR, 8'h00, 8'd123, 8'd3);
    send_word(MODE_RENDER, 8'h62, 8'h00, 8'h00);
    send_word(MODE_SET_CURSOR, 8'h00, 8'd10, 8'd7);
    send_word(MODE_RENDER, NEWLINE_CODE, 8'hAA, 8'h55);
    send_word(MODE_SET_CURSOR, 8'h00, 8'd0, 8'd0);
    send_word(MODE_RENDER, 8'h7F, 8'h00, 8'h00);
    send_word(MODE_RENDER, 8'h80, 8'h00, 8'h00);

    counted = 0;
    n = 0;
    while (counted < RANDOM_ITEMS) begin
      if (n == 60) no_idle = 1'b1;
      if (n == 130) no_idle = 1'b0;
      if (n == 180) hold_request = 1'b1;
      if (n == 300) wait_drained();
      r = $urandom_range(0, 99);
      if (r < 20) begin
        mode = MODE_SET_CURSOR;
        code = 8'($urandom);
        if ($urandom_range(0, 3) == 0) begin
          col  = 8'($urandom);
          page = 8'($urandom);
        end else begin
          col  = ($urandom_range(0, 3) == 0) ? 8'($urandom_range(110, 127)) :
                                               8'($urandom_range(0, 127));
          page = 8'($urandom_range(0, 7));
        end
        if (col < DISPLAY_COLUMNS && page < DISPLAY_PAGES) counted++;
      end else begin
        mode = MODE_RENDER;
        col  = 8'($urandom);
        page = 8'($urandom);
        q    = $urandom_range(0, 9);
        if (q == 0) code = NEWLINE_CODE;
        else if (q < 8) code = 8'($urandom_range(FONT_FIRST, FONT_FIRST + FONT_ENTRIES - 1));
        else code = 8'($urandom);
        counted++;
      end
      send_word(mode, code, col, page);
      n++;
    end

    wait_drained();
    repeat (16) @(posedge clk);
    if (mismatches == 0 && backlog == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

// ===== files.f =====
rtl/tgcs_pkg.sv
rtl/tgcs_font_rom.sv
rtl/text_glyph_column_streamer_top.sv
tb/sv/text_glyph_column_checker.sv
tb/sv/text_glyph_column_streamer_top_tb.sv
